// ===== design/gks_pkg.sv =====
// ----------------------------------------------------------------------------
// gks_pkg: shared types, constants and table builder
// Point word layout, sequencer states, pipeline tags and the exp(-y) entry
// function used to fill the kernel table at elaboration.
// ----------------------------------------------------------------------------
package gks_pkg;

  localparam int GKS_MAX_POINTS     = 64;
  localparam int GKS_EXP_TABLE_SIZE = 1024;

  localparam int REG_KERNEL_GAIN = 0;
  localparam int REG_INV_SIGMA   = 1;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
  } gks_point_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } gks_pos_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic fin;
  } gks_tag_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_DRAIN
  } gks_state_t;

  // exp(-16y), y in Q2.30, Taylor series then four squarings; Q1.16 result
  function automatic logic [16:0] gks_exp_entry(input logic [63:0] y);
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] prod;
    term = 64'd1 << 30;
    sum  = 64'd1 << 30;
    for (int n = 1; n <= 15; n++) begin
      prod = term * y;
      term = (prod >> 30) / 64'(n);
      if ((n % 2) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    for (int s = 0; s < 4; s++) begin
      prod = sum * sum;
      sum  = (prod + (64'd1 << 29)) >> 30;
    end
    prod = (sum + (64'd1 << 13)) >> 14;
    return prod[16:0];
  endfunction

endpackage

// ===== design/gks_cell.sv =====
// ----------------------------------------------------------------------------
// gks_cell: one point slot of the rotating store
// Takes a loaded word when its slot is addressed, otherwise on a shift moves the ring
// one place toward the head, wrapping at the last occupied slot.
// ----------------------------------------------------------------------------
module gks_cell
  import gks_pkg::*;
#(
  parameter int IDX = 0,
  parameter int IW  = 6
) (
  input  logic          clk,
  input  logic          load,
  input  logic [IW-1:0] slot,
  input  gks_point_t    load_word,
  input  logic          shift,
  input  logic [IW-1:0] last_slot,
  input  gks_point_t    nbr,
  input  gks_point_t    head,
  output gks_point_t    word
);

  logic hit;
  logic wrap;

  assign hit  = load && (slot == IW'(IDX));
  assign wrap = (last_slot == IW'(IDX));

  always_ff @(posedge clk) begin
    if (hit) begin
      word <= load_word;
    end else if (shift) begin
      word <= wrap ? head : nbr;
    end
  end

endmodule

// ===== design/gks_pair.sv =====
// ----------------------------------------------------------------------------
// gks_pair: pipelined pair evaluator and row accumulator
// Distance, scaled index, kernel table, gain, weighting and saturating
// sum over one row; the finished row lands in the output register.
// ----------------------------------------------------------------------------
module gks_pair
  import gks_pkg::*;
#(
  parameter int EXP_TABLE_SIZE = GKS_EXP_TABLE_SIZE
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  gks_tag_t           tag_in,
  input  gks_pos_t           pi,
  input  gks_point_t         pj,
  input  logic [31:0]        kernel_gain,
  input  logic [31:0]        inv_sigma_sq,
  input  logic               out_stall,
  output logic               out_valid,
  output logic signed [47:0] sum_x,
  output logic signed [47:0] sum_y,
  output logic signed [47:0] sum_z,
  output logic               final_result,
  output logic               busy
);

  localparam int IDXW  = $clog2(EXP_TABLE_SIZE);
  localparam int PRODW = 32 + IDXW + 1;

  logic [16:0] exp_rom [EXP_TABLE_SIZE];

  for (genvar k = 0; k < EXP_TABLE_SIZE; k++) begin : g_rom
    localparam logic [63:0] Y = (64'(k) << 30) / EXP_TABLE_SIZE;
    assign exp_rom[k] = gks_exp_entry(Y);
  end

  gks_tag_t tag [1:9];
  logic [95:0] w [1:8];

  logic [31:0] mx, my, mz;
  logic [47:0] qx, qy, qz;
  logic [49:0] d2;
  logic [49:0] hi;
  logic [63:0] lo;
  logic [31:0] a;
  logic        kill;
  logic [IDXW-1:0] idx;
  logic        zero;
  logic [16:0] kern;
  logic [32:0] c;
  logic [48:0] tx, ty, tz;
  logic        nx, ny, nz;

  logic signed [47:0] acc_x, acc_y, acc_z;

  logic signed [32:0] dx, dy, dz;
  logic [48:0]        a_wide;
  logic [PRODW-1:0]   a_prod;
  logic [PRODW-21:0]  idx_wide;
  logic [48:0]        c_wide;

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic signed [32:0] m;
    m = v[32] ? -v : v;
    return m[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [32:0] m;
    m = v[31] ? -{v[31], v} : {v[31], v};
    return m[31:0];
  endfunction

  function automatic logic [48:0] wterm(input logic [32:0] cc, input logic [31:0] wm);
    logic [64:0] m;
    m = 65'(cc) * 65'(wm);
    return m[64:16];
  endfunction

  function automatic logic signed [47:0] sat_acc(
    input logic signed [47:0] base,
    input logic [48:0]        t,
    input logic               neg
  );
    logic signed [50:0] st;
    logic signed [50:0] s;
    st = neg ? -$signed({2'b00, t}) : $signed({2'b00, t});
    s  = 51'(base) + st;
    if (s > 51'sh7FFFFFFFFFFF) begin
      return 48'sh7FFFFFFFFFFF;
    end else if (s < -51'sh800000000000) begin
      return -48'sh800000000000;
    end
    return s[47:0];
  endfunction

  assign dx = {pi.px[31], pi.px} - {pj.px[31], pj.px};
  assign dy = {pi.py[31], pi.py} - {pj.py[31], pj.py};
  assign dz = {pi.pz[31], pi.pz} - {pj.pz[31], pj.pz};

  assign a_wide   = {hi[15:0], 16'd0} + 49'(lo[63:16]);
  assign a_prod   = PRODW'(a) * PRODW'(EXP_TABLE_SIZE);
  assign idx_wide = a_prod[PRODW-1:20];
  assign c_wide   = 49'(kernel_gain) * 49'(kern);

  // control: stage valid and row tags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= 9; s++) begin
        tag[s] <= '0;
      end
    end else if (en) begin
      tag[1] <= tag_in;
      for (int s = 2; s <= 9; s++) begin
        tag[s] <= tag[s-1];
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      mx <= mag33(dx);
      my <= mag33(dy);
      mz <= mag33(dz);
      w[1] <= {pj.wx, pj.wy, pj.wz};
      for (int s = 2; s <= 8; s++) begin
        w[s] <= w[s-1];
      end
      qx <= 48'((64'(mx) * 64'(mx)) >> 16);
      qy <= 48'((64'(my) * 64'(my)) >> 16);
      qz <= 48'((64'(mz) * 64'(mz)) >> 16);
      d2 <= 50'(qx) + 50'(qy) + 50'(qz);
      hi <= 50'(d2[49:32]) * 50'(inv_sigma_sq);
      lo <= 64'(d2[31:0]) * 64'(inv_sigma_sq);
      kill <= (hi >= 50'h10000);
      a <= (a_wide > 49'hFFFFFFFF) ? 32'hFFFFFFFF : a_wide[31:0];
      zero <= kill || (idx_wide >= (PRODW-20)'(EXP_TABLE_SIZE));
      idx  <= idx_wide[IDXW-1:0];
      kern <= zero ? 17'd0 : exp_rom[idx];
      c <= c_wide[48:16];
      tx <= wterm(c, mag32(w[8][95:64]));
      ty <= wterm(c, mag32(w[8][63:32]));
      tz <= wterm(c, mag32(w[8][31:0]));
      nx <= w[8][95];
      ny <= w[8][63];
      nz <= w[8][31];
      if (tag[9].valid) begin
        acc_x <= sat_acc(tag[9].first ? 48'sd0 : acc_x, tx, nx);
        acc_y <= sat_acc(tag[9].first ? 48'sd0 : acc_y, ty, ny);
        acc_z <= sat_acc(tag[9].first ? 48'sd0 : acc_z, tz, nz);
      end
    end
  end

  // output register: the row total lands once its last term is in
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && tag[9].valid && tag[9].last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && tag[9].valid && tag[9].last) begin
      sum_x        <= sat_acc(tag[9].first ? 48'sd0 : acc_x, tx, nx);
      sum_y        <= sat_acc(tag[9].first ? 48'sd0 : acc_y, ty, ny);
      sum_z        <= sat_acc(tag[9].first ? 48'sd0 : acc_z, tz, nz);
      final_result <= tag[9].fin;
    end
  end

  always_comb begin
    busy = 1'b0;
    for (int s = 1; s <= 9; s++) begin
      busy = busy | tag[s].valid;
    end
  end

endmodule

// ===== design/gaussian_kernel_sum_unit.sv =====
// ----------------------------------------------------------------------------
// gaussian_kernel_sum_unit: direct 3-D Gaussian kernel summation
// A non-final word is taken while the unit is loading. A set of n points yields n
// results after the final word, one per row: one pair per cycle through the pair
// pipeline while the output is not stalled, paced by the rotating ring of point
// cells. Synchronous reset empties the store and sets both registers to 1.0;
// the store itself is not cleared.
// ----------------------------------------------------------------------------
module gaussian_kernel_sum_unit
  import gks_pkg::*;
#(
  parameter int MAX_POINTS     = GKS_MAX_POINTS,
  parameter int EXP_TABLE_SIZE = GKS_EXP_TABLE_SIZE
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] wt_x,
  input  logic signed [31:0] wt_y,
  input  logic signed [31:0] wt_z,
  input  logic               final_point,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] sum_x,
  output logic signed [47:0] sum_y,
  output logic signed [47:0] sum_z,
  output logic               final_result
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  gks_state_t state, state_next;

  logic [31:0]   kernel_gain;
  logic [31:0]   inv_sigma_sq;
  logic [CW-1:0] count;
  logic [IW-1:0] col;
  logic [IW-1:0] row;
  gks_pos_t      pi;
  gks_pos_t      pi_next;

  logic          accept;
  logic          room;
  logic          en;
  logic          issue;
  logic          busy;
  logic [IW-1:0] last_slot;
  logic          row_end;
  logic          at_next;
  gks_tag_t      tag_in;
  gks_point_t    in_word;
  gks_point_t    cells [MAX_POINTS];

  assign in_word   = '{px: pos_x, py: pos_y, pz: pos_z, wx: wt_x, wy: wt_y, wz: wt_z};
  assign room      = (count < CW'(MAX_POINTS));
  assign accept    = in_valid && !in_stall;
  assign en        = !(out_valid && out_stall);
  assign last_slot = IW'(count - CW'(1));
  assign row_end   = (col == last_slot);
  assign at_next   = ((IW + 1)'(col) == (IW + 1)'(row) + (IW + 1)'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_gain  <= 32'h0001_0000;
      inv_sigma_sq <= 32'h0001_0000;
    end else if (cfg_we) begin
      case (cfg_index)
        2'(REG_KERNEL_GAIN): kernel_gain  <= cfg_data;
        2'(REG_INV_SIGMA):   inv_sigma_sq <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:  if (accept && final_point) state_next = ST_RUN;
      ST_RUN:   if (en && row_end && (row == last_slot)) state_next = ST_DRAIN;
      ST_DRAIN: if (!busy && !out_valid) state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_LOAD);
    issue    = (state == ST_RUN) && en;
    tag_in.valid = (state == ST_RUN);
    tag_in.first = (col == '0);
    tag_in.last  = row_end;
    tag_in.fin   = row_end && (row == last_slot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      col   <= '0;
      row   <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_LOAD: begin
          if (accept && room) count <= count + CW'(1);
          col <= '0;
          row <= '0;
        end
        ST_RUN: begin
          if (issue) begin
            if (row_end) begin
              col <= '0;
              row <= row + IW'(1);
            end else begin
              col <= col + IW'(1);
            end
          end
        end
        ST_DRAIN: begin
          if (state_next == ST_LOAD) count <= '0;
        end
        default: ;
      endcase
    end
  end

  // row point: first from the load, then picked off the head one row ahead;
  // take the head directly when the next row point arrives on the row end
  always_ff @(posedge clk) begin
    if (accept && (count == '0)) begin
      pi <= '{px: pos_x, py: pos_y, pz: pos_z};
    end else if (issue && row_end) begin
      if (at_next) begin
        pi <= '{px: cells[0].px, py: cells[0].py, pz: cells[0].pz};
      end else begin
        pi <= pi_next;
      end
    end
    if (issue && at_next) begin
      pi_next <= '{px: cells[0].px, py: cells[0].py, pz: cells[0].pz};
    end
  end

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    gks_cell #(
      .IDX (k),
      .IW  (IW)
    ) u_cell (
      .clk       (clk),
      .load      (accept && room),
      .slot      (count[IW-1:0]),
      .load_word (in_word),
      .shift     (issue),
      .last_slot (last_slot),
      .nbr       (cells[(k + 1) % MAX_POINTS]),
      .head      (cells[0]),
      .word      (cells[k])
    );
  end

  gks_pair #(
    .EXP_TABLE_SIZE (EXP_TABLE_SIZE)
  ) u_pair (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .tag_in       (tag_in),
    .pi           (pi),
    .pj           (cells[0]),
    .kernel_gain  (kernel_gain),
    .inv_sigma_sq (inv_sigma_sq),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .sum_x        (sum_x),
    .sum_y        (sum_y),
    .sum_z        (sum_z),
    .final_result (final_result),
    .busy         (busy)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("point count past store depth");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> !busy)
    else $error("pair pipeline busy while loading");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> ((col <= last_slot) && (row <= last_slot) && (count != '0)))
    else $error("ring position outside the stored set");

endmodule
